// ===== src/sobm_pkg.sv =====
// shared constants, types and square root step for the sobel edge magnitude core
package sobm_pkg;

  // configuration register layout
  localparam int unsigned LINE_WIDTH_W   = 11;
  localparam int unsigned FRAME_HEIGHT_W = 13;
  localparam int unsigned CFG_DATA_W     = 13;
  localparam int unsigned CFG_ADDR_W     = 1;

  localparam logic [CFG_ADDR_W-1:0] REG_LINE_WIDTH   = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  localparam logic [LINE_WIDTH_W-1:0]   LINE_WIDTH_RST   = 11'd1024;
  localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 13'd768;

  // frame geometry
  localparam int unsigned MAX_WIDTH_DEF = 1024;
  localparam int unsigned MAX_HEIGHT    = 4096;
  localparam int unsigned MIN_DIM       = 3;
  localparam int unsigned ROW_W         = 12;

  // datapath widths
  localparam int unsigned PIX_W  = 8;
  localparam int unsigned SUM_W  = 17;
  localparam int unsigned ROOT_W = 9;
  localparam int unsigned SQ_D_W = 19;

  // root pipeline: three stages, three result bits each
  localparam int unsigned ROOT_STAGES   = 3;
  localparam int unsigned ROOT_PER_STEP = 3;

  typedef struct packed {
    logic [SUM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_st_t;

  // one restoring square root step for result bit b
  function automatic sq_st_t sq_step(sq_st_t st, int unsigned b);
    logic [SQ_D_W-1:0] d;
    sq_st_t res;
    res = st;
    d = (SQ_D_W'(st.root) << (b + 1)) | (SQ_D_W'(1) << (2 * b));
    if (SQ_D_W'(st.rem) >= d) begin
      res.rem  = st.rem - SUM_W'(d);
      res.root = st.root | (ROOT_W'(1) << b);
    end
    return res;
  endfunction

endpackage

// ===== src/sobm_ram.sv =====
// simple dual port ram, one write and one registered read per cycle
module sobm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port, holds while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/sobel_edge_magnitude_core.sv =====
// 3x3 sobel gradient magnitude over a raster pixel stream
// throughput: one pixel per clock while no result is stalled, set by the line ram (one read and one write each cycle)
// the result of the pixel that completes a window passes stages 1 to 5, the root stages and the output register
// the whole pipeline stalls while a result waits on out_tready
// reset clears counters, window, valid bits and config (width 1024, height 768)
// the line ram is not cleared; rows 0 and 1 of a frame never use its contents
module sobel_edge_magnitude_core import sobm_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // pixel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,
  // magnitude
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,
  output logic                  out_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned WW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CMPW = (WW > LINE_WIDTH_W) ? WW : LINE_WIDTH_W;
  localparam int unsigned LW   = 2 * PIX_W;

  // configuration registers
  logic [LINE_WIDTH_W-1:0]   line_width_r;
  logic [FRAME_HEIGHT_W-1:0] frame_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r   <= LINE_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_LINE_WIDTH:   line_width_r   <= cfg_wdata[LINE_WIDTH_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata[FRAME_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp geometry to the supported range
  logic [CMPW-1:0]           lw_ext;
  logic [CMPW-1:0]           w_use;
  logic [FRAME_HEIGHT_W-1:0] h_use;
  logic [CW-1:0]             col_last;
  logic [ROW_W-1:0]          row_last;

  assign lw_ext = CMPW'(line_width_r);

  always_comb begin
    if (lw_ext < CMPW'(MIN_DIM)) begin
      w_use = CMPW'(MIN_DIM);
    end else if (lw_ext > CMPW'(MAX_WIDTH)) begin
      w_use = CMPW'(MAX_WIDTH);
    end else begin
      w_use = lw_ext;
    end
    if (frame_height_r < FRAME_HEIGHT_W'(MIN_DIM)) begin
      h_use = FRAME_HEIGHT_W'(MIN_DIM);
    end else if (frame_height_r > FRAME_HEIGHT_W'(MAX_HEIGHT)) begin
      h_use = FRAME_HEIGHT_W'(MAX_HEIGHT);
    end else begin
      h_use = frame_height_r;
    end
  end

  assign col_last = CW'(w_use - CMPW'(1));
  assign row_last = ROW_W'(h_use - FRAME_HEIGHT_W'(1));

  // global pipeline advance: everything moves when the output slot is free or its result is taken
  logic adv;
  logic acc;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;
  assign acc       = in_tvalid && adv;

  // raster position counters
  logic [CW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             col_end, row_end, emit, last;

  assign col_end = col_r >= col_last;
  assign row_end = row_r >= row_last;
  assign emit    = (row_r >= ROW_W'(2)) && (col_r >= CW'(2));
  assign last    = row_end && col_end;

  always_comb begin
    col_nxt = col_r + CW'(1);
    row_nxt = row_r;
    if (col_end) begin
      col_nxt = '0;
      row_nxt = row_end ? '0 : row_r + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // stage 1: pixel waits for the line ram read
  logic             s1_v_r, s1_emit_r, s1_last_r;
  logic [CW-1:0]    s1_col_r;
  logic [PIX_W-1:0] s1_pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_emit_r <= emit;
      s1_last_r <= last;
      s1_col_r  <= col_r;
      s1_pix_r  <= in_tdata;
    end
  end

  // line ram: upper byte two rows up, lower byte one row up
  // the same column recurs only after at least three pixels, so a read
  // never meets a pending write and no forwarding is needed
  logic [LW-1:0]    ram_rd;
  logic [PIX_W-1:0] top, mid, bot;

  assign top = ram_rd[LW-1:PIX_W];
  assign mid = ram_rd[PIX_W-1:0];
  assign bot = s1_pix_r;

  sobm_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (s1_v_r && adv),
    .wr_addr (s1_col_r),
    .wr_data ({mid, bot}),
    .rd_en   (acc),
    .rd_addr (col_r),
    .rd_data (ram_rd)
  );

  // window of the two previous columns: top, middle, bottom
  logic [PIX_W-1:0] win_r [6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (s1_v_r && adv) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= top;
      win_r[4] <= mid;
      win_r[5] <= bot;
    end
  end

  // sobel sums
  logic signed [11:0] sx_nxt, sy_nxt;

  always_comb begin
    sx_nxt = $signed(12'(win_r[0]) + {3'b0, win_r[1], 1'b0} + 12'(win_r[2]))
           - $signed(12'(top) + {3'b0, mid, 1'b0} + 12'(bot));
    sy_nxt = $signed(12'(win_r[0]) + {3'b0, win_r[3], 1'b0} + 12'(top))
           - $signed(12'(win_r[2]) + {3'b0, win_r[5], 1'b0} + 12'(bot));
  end

  // stage 2: signed sums
  logic               s2_v_r, s2_last_r;
  logic signed [11:0] sx_r, sy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r && s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_last_r <= s1_last_r;
      sx_r      <= sx_nxt;
      sy_r      <= sy_nxt;
    end
  end

  // absolute value, quarter, round half away from zero
  logic [11:0]      ax, ay;
  logic [PIX_W-1:0] gx_nxt, gy_nxt;

  always_comb begin
    ax     = sx_r[11] ? 12'(-sx_r) : 12'(sx_r);
    ay     = sy_r[11] ? 12'(-sy_r) : 12'(sy_r);
    gx_nxt = PIX_W'((ax + 12'd2) >> 2);
    gy_nxt = PIX_W'((ay + 12'd2) >> 2);
  end

  // stage 3: gradient components
  logic             s3_v_r, s3_last_r;
  logic [PIX_W-1:0] gx_r, gy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_last_r <= s2_last_r;
      gx_r      <= gx_nxt;
      gy_r      <= gy_nxt;
    end
  end

  // stage 4: squares
  logic          s4_v_r, s4_last_r;
  logic [LW-1:0] sqx_r, sqy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (adv) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_last_r <= s3_last_r;
      sqx_r     <= gx_r * gy_r * 16'd0 + LW'(gx_r) * LW'(gx_r);
      sqy_r     <= LW'(gy_r) * LW'(gy_r);
    end
  end

  // stage 5: sum of squares
  logic             s5_v_r, s5_last_r;
  logic [SUM_W-1:0] sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (adv) begin
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_last_r <= s4_last_r;
      sum_r     <= SUM_W'(sqx_r) + SUM_W'(sqy_r);
    end
  end

  // square root pipeline, three result bits per stage
  sq_st_t rt_in  [ROOT_STAGES];
  sq_st_t rt_nxt [ROOT_STAGES];
  sq_st_t rt_r   [ROOT_STAGES];
  logic   rt_v_r    [ROOT_STAGES];
  logic   rt_last_r [ROOT_STAGES];

  always_comb begin
    for (int k = 0; k < ROOT_STAGES; k++) begin
      if (k == 0) begin
        rt_in[k].rem  = sum_r;
        rt_in[k].root = '0;
      end else begin
        rt_in[k] = rt_r[k-1];
      end
      rt_nxt[k] = rt_in[k];
      for (int j = 0; j < ROOT_PER_STEP; j++) begin
        rt_nxt[k] = sq_step(rt_nxt[k], ROOT_W - 1 - k * ROOT_PER_STEP - j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < ROOT_STAGES; k++) begin
        rt_v_r[k] <= 1'b0;
      end
    end else if (adv) begin
      rt_v_r[0] <= s5_v_r;
      for (int k = 1; k < ROOT_STAGES; k++) begin
        rt_v_r[k] <= rt_v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rt_last_r[0] <= s5_last_r;
      for (int k = 1; k < ROOT_STAGES; k++) begin
        rt_last_r[k] <= rt_last_r[k-1];
      end
      for (int k = 0; k < ROOT_STAGES; k++) begin
        rt_r[k] <= rt_nxt[k];
      end
    end
  end

  // round to nearest and saturate
  sq_st_t           rt_fin;
  logic [ROOT_W:0]  rnd;
  logic [PIX_W-1:0] mag_nxt;

  assign rt_fin = rt_r[ROOT_STAGES-1];

  always_comb begin
    rnd = {1'b0, rt_fin.root};
    if (rt_fin.rem > SUM_W'(rt_fin.root)) begin
      rnd = rnd + (ROOT_W + 1)'(1);
    end
    mag_nxt = (rnd > (ROOT_W + 1)'(255)) ? PIX_W'(255) : rnd[PIX_W-1:0];
  end

  // output register
  logic             out_valid_r, out_last_r;
  logic [PIX_W-1:0] out_mag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= rt_v_r[ROOT_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_mag_r  <= mag_nxt;
      out_last_r <= rt_last_r[ROOT_STAGES-1];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_mag_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== src/sobm_checker.sv =====
// port level checks for the sobel edge magnitude core, bound to the top level
module sobm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result word present after reset");

  // a waiting result holds its word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result word changed while stalled");

  // a stalled result stalls the pixel input
  a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("pixel accepted while result stalled");

  // a free output slot always releases the input side
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input not ready with empty output slot");

endmodule

bind sobel_edge_magnitude_core sobm_checker u_sobm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
